// ----- design/mqbp_pkg.sv -----
// Package for the moment quantizer and bit packer.
// Holds the shared widths, constants, beat types and the back-end state type.
// No dependencies.
package mqbp_pkg;

  localparam int FRACTION_BITS  = 30;
  localparam int MAX_CODE_WIDTH = 31;

  localparam int SAMPLE_W = 32;
  localparam int CW_W     = 5;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + MAX_CODE_WIDTH;
  localparam int QUO_W    = MAX_CODE_WIDTH;
  localparam int ACC_W    = 7;
  localparam int CNT_W    = 3;
  localparam int PACK_W   = QUO_W + ACC_W;
  localparam int TOTAL_W  = 6;
  localparam int NBYTE_W  = 3;
  localparam int OBUF_W   = 32;
  localparam int IDX_W    = $clog2(QUO_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SAMPLE_W-1:0] RANGE_MIN_RESET = -32'sd341782638;
  localparam logic signed [SAMPLE_W-1:0] RANGE_MAX_RESET = 32'sd341782638;
  localparam logic signed [DIFF_W-1:0]   ONE_FIXED = DIFF_W'(1) << FRACTION_BITS;

  // Configuration register indexes
  localparam logic REG_RANGE_MIN = 1'b0;
  localparam logic REG_RANGE_MAX = 1'b1;

  // Item actions
  localparam logic ACT_QUANT = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_zeroth;
    logic [CW_W-1:0]            code_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last;
  } out_item_t;

  // Classified work entry passed from front to back
  typedef struct packed {
    logic              flush;
    logic              zero_code;
    logic [CW_W-1:0]   width;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] span;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SHIFT,
    ST_DIV,
    ST_PACK,
    ST_EMIT
  } back_state_t;

endpackage

// ----- design/mqbp_front.sv -----
// Front end: configuration registers, clamping and range classification.
// Depends on mqbp_pkg.
module mqbp_front import mqbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                q_push,
  output job_t                q_entry,
  input  logic                q_full
);

  logic signed [SAMPLE_W-1:0] range_min;
  logic signed [SAMPLE_W-1:0] range_max;

  logic signed [DIFF_W-1:0] lo;
  logic signed [DIFF_W-1:0] hi;
  logic signed [DIFF_W-1:0] smp;
  logic signed [DIFF_W-1:0] clamped;
  logic [CW_W-1:0]          width;
  logic                     empty_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= RANGE_MIN_RESET;
      range_max <= RANGE_MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RANGE_MIN: range_min <= cfg_data;
        REG_RANGE_MAX: range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lo  = in_data.is_zeroth ? '0 : DIFF_W'(range_min);
    hi  = in_data.is_zeroth ? ONE_FIXED : DIFF_W'(range_max);
    smp = DIFF_W'(in_data.sample);
    empty_range = (hi <= lo);
    if (smp < lo) begin
      clamped = lo;
    end else if (smp > hi) begin
      clamped = hi;
    end else begin
      clamped = smp;
    end
    width = (in_data.code_width > CW_W'(MAX_CODE_WIDTH)) ? CW_W'(MAX_CODE_WIDTH)
                                                         : in_data.code_width;
    q_entry.flush     = (in_data.action == ACT_FLUSH);
    q_entry.zero_code = empty_range || (width == '0);
    q_entry.width     = width;
    q_entry.diff      = clamped - lo;
    q_entry.span      = hi - lo;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ----- design/mqbp_queue.sv -----
// Short work queue between the front and back ends.
// Depends on mqbp_pkg.
module mqbp_queue import mqbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_entry,
  output logic full,
  input  logic pop,
  output job_t pop_entry,
  output logic nonempty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty  = (count != '0);
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/mqbp_back.sv -----
// Back end: code computation by restoring division, bit packing, byte output.
// Depends on mqbp_pkg.
module mqbp_back import mqbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  job_t      q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  back_state_t state;
  back_state_t state_next;

  job_t                 job;
  logic [PROD_W-1:0]    prod;
  logic [DIFF_W-1:0]    rem;
  logic [QUO_W-1:0]     plow;
  logic [IDX_W-1:0]     idx;
  logic [QUO_W-1:0]     quo;
  logic [ACC_W-1:0]     acc;
  logic [CNT_W-1:0]     cnt;
  logic [OBUF_W-1:0]    obuf;
  logic [NBYTE_W-1:0]   left;

  logic                 load_out;
  logic [DIFF_W:0]      trial;
  logic [DIFF_W:0]      trial_sub;
  logic                 trial_ge;
  logic [QUO_W-1:0]     code;
  logic [PACK_W-1:0]    pack_word;
  logic [PACK_W-1:0]    pack_rest;
  logic [TOTAL_W-1:0]   total;
  logic [NBYTE_W-1:0]   nbytes;

  // Datapath helpers
  always_comb begin
    trial     = {rem, plow[idx]};
    trial_sub = trial - {1'b0, job.span};
    trial_ge  = (trial >= {1'b0, job.span});
    code      = job.zero_code ? '0 : quo;
    pack_word = ({{ACC_W{1'b0}}, code} << cnt) | {{QUO_W{1'b0}}, acc};
    total     = TOTAL_W'(cnt) + TOTAL_W'(job.width);
    nbytes    = total[TOTAL_W-1:3];
    pack_rest = pack_word >> {nbytes, 3'b000};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_nonempty) begin
          q_pop = 1'b1;
          if (q_entry.flush) begin
            state_next = (cnt != '0) ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = q_entry.zero_code ? ST_PACK : ST_MUL;
          end
        end
      end
      ST_MUL:   state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_DIV;
      ST_DIV: begin
        if (idx == '0) begin
          state_next = ST_PACK;
        end
      end
      ST_PACK:  state_next = (nbytes == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: begin
        load_out = !out_valid || !out_stall;
        if (load_out && left == NBYTE_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (state == ST_IDLE && q_nonempty && q_entry.flush) begin
      acc <= '0;
      cnt <= '0;
    end else if (state == ST_PACK) begin
      acc <= pack_rest[ACC_W-1:0];
      cnt <= total[CNT_W-1:0];
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_nonempty) begin
          job  <= q_entry;
          quo  <= '0;
          obuf <= OBUF_W'(acc);
          left <= NBYTE_W'(1);
        end
      end
      ST_MUL: begin
        prod <= (PROD_W'(job.diff) << job.width) - PROD_W'(job.diff);
      end
      ST_SHIFT: begin
        rem  <= DIFF_W'(prod >> job.width);
        plow <= prod[QUO_W-1:0];
        idx  <= IDX_W'(job.width - 1'b1);
      end
      ST_DIV: begin
        rem <= trial_ge ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
        quo <= {quo[QUO_W-2:0], trial_ge};
        idx <= idx - 1'b1;
      end
      ST_PACK: begin
        obuf <= pack_word[OBUF_W-1:0];
        left <= nbytes;
      end
      ST_EMIT: begin
        if (load_out) begin
          obuf <= obuf >> 8;
          left <= left - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.packed_byte <= obuf[7:0];
      out_data.last        <= (left == NBYTE_W'(1));
    end
  end

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < job.span)
    else $error("division remainder not below span");

  a_code_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PACK && !job.zero_code) |-> (quo >> job.width) == '0)
    else $error("code wider than its width");

  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc >> cnt) == '0)
    else $error("stray bits above pending count");

  a_emit_has_bytes: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> left != '0)
    else $error("emit with no bytes left");

endmodule

// ----- design/moment_quantize_bit_packer.sv -----
// Moment quantizer with LSB-first byte packer: top level.
// Depends on mqbp_pkg, mqbp_front, mqbp_queue and mqbp_back.
// Quantize items pass the front and queue to back-end states MUL, SHIFT, DIV (one bit
//   per cycle) and PACK, then EMIT and the output register once whole bytes are ready; an
//   empty range or zero width skips MUL, SHIFT and DIV. New items start only in IDLE.
// A flush goes to EMIT only with bits pending. Reset (sync, active high)
// restores the ranges, empties the accumulator and the queue; no clearing pass is needed.
module moment_quantize_bit_packer import mqbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  // Front classifies each beat into a job: clamp, diff and span, or flush.
  job_t push_entry;
  job_t pop_entry;
  logic push;
  logic pop;
  logic full;
  logic nonempty;

  mqbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_push    (push),
    .q_entry   (push_entry),
    .q_full    (full)
  );

  // Queue decouples the front from the multi-cycle back end, so new beats
  // are taken while a code is still being divided or bytes wait to drain.
  mqbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .nonempty   (nonempty)
  );

  // Back end: form diff*(2^w-1), divide by span one bit per cycle, append
  // the code to the pending bits and drain whole bytes through the output
  // register, marking the final byte of each item with last.
  mqbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (nonempty),
    .q_entry    (pop_entry),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- verif/moment_quantize_bit_packer_tb.sv -----
// Self-checking testbench for moment_quantize_bit_packer (quantizer + LSB-first byte packer).
// Uses mqbp_pkg for beat types, widths and codes; needs nothing else but the RTL.
// A directed table runs first, then random phases over several range settings.
`timescale 1ns / 100ps

module moment_quantize_bit_packer_tb;
  import mqbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // Items that emit nothing may still sit in the queue and back end when the
  // last byte arrives: up to two in the queue and one in the back end.
  localparam int SETTLE      = 200;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 45;

  typedef enum logic [1:0] {ROW_ITEM, ROW_MIN, ROW_MAX} row_kind_t;

  // One line of the directed plan. Register rows carry their value in item.sample.
  // A row with typed set carries its expectation by hand (at most one byte).
  typedef struct {
    row_kind_t  kind;
    in_item_t   item;
    bit         typed;
    int         typed_n;
    logic [7:0] typed_byte;
  } plan_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_RANGE_MIN;
  logic [SAMPLE_W-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;

  // Predictor copy of the block state and ranges
  logic signed [SAMPLE_W-1:0] rng_min = RANGE_MIN_RESET;
  logic signed [SAMPLE_W-1:0] rng_max = RANGE_MAX_RESET;
  logic [ACC_W-1:0]           acc_bits = '0;
  logic [CNT_W-1:0]           acc_cnt  = '0;

  out_item_t bytes_due[$];   // bytes still owed by the block, oldest first
  plan_row_t plan[$];

  bit calm = 1'b0;           // when set, neither side idles
  int cycles      = 0;
  int errors      = 0;
  int checked     = 0;
  int items_sent  = 0;
  int flush_sent  = 0;
  int reg_writes  = 0;
  int stall_left  = 0;

  moment_quantize_bit_packer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for one beat on either side; at least a third of the draws are zero.
  function automatic int idle_draw();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Append one owed byte at the tail of the expectation queue.
  function automatic void owe_byte(input out_item_t b);
    bytes_due.insert(bytes_due.size(), b);
  endfunction

  // Append one row at the end of the directed plan.
  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // Code level: floor((v - lo) * (2^w - 1) / (hi - lo)) after clamping, 0 on an empty range or zero width.
  function automatic logic [63:0] level_of(logic signed [SAMPLE_W-1:0] s, logic zeroth,
                                           int w);
    longint      lo, hi, v;
    logic [63:0] span, diff, levels;
    lo = zeroth ? 64'sd0 : longint'(rng_min);
    hi = zeroth ? (longint'(1) << FRACTION_BITS) : longint'(rng_max);
    if (w == 0 || hi <= lo) return 64'd0;
    v = longint'(s);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    span   = 64'(hi - lo);
    diff   = 64'(v - lo);
    levels = (64'd1 << w) - 64'd1;
    return (diff * levels) / span;
  endfunction

  // Advance the packer state by one item; return the bytes it completes.
  function automatic int pack_item(input in_item_t it, output out_item_t res [4]);
    logic [63:0] bits;
    int          total, n;
    n = 0;
    foreach (res[i]) res[i] = '0;
    if (it.action == ACT_FLUSH) begin
      if (acc_cnt == 0) return 0;
      res[0].packed_byte = {1'b0, acc_bits};
      res[0].last        = 1'b1;
      acc_bits = '0;
      acc_cnt  = '0;
      return 1;
    end
    bits  = {57'd0, acc_bits} | (level_of(it.sample, it.is_zeroth, it.code_width) << acc_cnt);
    total = int'(acc_cnt) + int'(it.code_width);
    while (total >= 8) begin
      res[n].packed_byte = bits[7:0];
      res[n].last        = 1'b0;
      bits  = bits >> 8;
      total = total - 8;
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    acc_bits = bits[ACC_W-1:0];
    acc_cnt  = CNT_W'(total);
    return n;
  endfunction

  function automatic plan_row_t mk(row_kind_t k, logic act, logic [31:0] s, logic z, int w,
                                   bit typed, int tn, logic [7:0] tb);
    plan_row_t r;
    r.kind                 = k;
    r.item.action          = act;
    r.item.sample          = s;
    r.item.is_zeroth       = z;
    r.item.code_width      = CW_W'(w);
    r.typed                = typed;
    r.typed_n              = tn;
    r.typed_byte           = tb;
    return r;
  endfunction

  // Random item: about half the samples inside the active range, then bounds, extremes, noise.
  function automatic in_item_t draw_item();
    in_item_t    it;
    longint      lo, hi;
    logic [63:0] off;
    int          pick;
    it.action     = ($urandom_range(0, 99) < 12) ? ACT_FLUSH : ACT_QUANT;
    it.is_zeroth  = ($urandom_range(0, 3) == 0);
    it.code_width = ($urandom_range(0, 19) == 0) ? CW_W'(0) : CW_W'($urandom_range(1, 31));
    lo = it.is_zeroth ? 64'sd0 : longint'(rng_min);
    hi = it.is_zeroth ? (longint'(1) << FRACTION_BITS) : longint'(rng_max);
    pick = $urandom_range(0, 99);
    if (pick < 50 && hi > lo) begin
      off       = {$urandom, $urandom} % 64'(hi - lo + 1);
      it.sample = 32'(lo + longint'(off));
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0:       it.sample = 32'(lo);
        1:       it.sample = 32'(lo - 1);
        2:       it.sample = 32'(hi);
        default: it.sample = 32'(hi + 1);
      endcase
    end else if (pick < 80) begin
      case ($urandom_range(0, 3))
        0:       it.sample = 32'h8000_0000;
        1:       it.sample = 32'h7FFF_FFFF;
        2:       it.sample = 32'h0000_0000;
        default: it.sample = 32'hFFFF_FFFF;
      endcase
    end else begin
      it.sample = $urandom;
    end
    return it;
  endfunction

  // Hold the sender off until every owed byte has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  // Write one range register with the block idle, and mirror it in the predictor.
  task automatic write_reg(input logic idx, input logic [SAMPLE_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_RANGE_MIN) rng_min = value;
    else rng_max = value;
    reg_writes++;
  endtask

  // Present one beat after a random gap, wait for it to be taken, then book
  // either the hand-typed bytes or what the predictor says.
  task automatic send_and_book(input in_item_t it, input bit typed, input int tn,
                               input logic [7:0] tb);
    out_item_t res [4];
    out_item_t hand;
    int        gap, n;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.action == ACT_FLUSH) flush_sent++;
    n = pack_item(it, res);
    if (typed) begin
      if (tn != 0) begin
        hand.packed_byte = tb;
        hand.last        = 1'b1;
        owe_byte(hand);
      end
    end else begin
      for (int i = 0; i < n; i++) owe_byte(res[i]);
    end
  endtask

  // Receiver: after each taken byte, draw how long to stall the next one.
  always @(posedge clk) begin
    int rx_hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid === 1'b1 && !out_stall) begin
      rx_hold = idle_draw();
      stall_left <= rx_hold;
      out_stall  <= (rx_hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Compare every taken byte against the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                 $time, out_data.packed_byte, out_data.last);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        checked++;
        if (out_data.packed_byte !== want.packed_byte) begin
          $display("%0t: packed_byte mismatch: expected %02h, actual %02h",
                   $time, want.packed_byte, out_data.packed_byte);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b",
                   $time, want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycles, bytes_due.size());
      $display("moment_quantize_bit_packer_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] lo_val, hi_val;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan. Ranges start at their reset values, accumulator empty.
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'h0000_0000, 1'b0, 0,  1, 0, 8'h00)); // empty flush
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h4000_0000, 1'b1, 8,  1, 1, 8'hFF)); // 1.0 -> top
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h8000_0000, 1'b1, 8,  1, 1, 8'h00)); // clamp low
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h7FFF_FFFF, 1'b1, 8,  1, 1, 8'hFF)); // clamp high
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h7FFF_FFFF, 1'b0, 31, 0, 0, 8'h00)); // widest code
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'hFFFF_FFFF, 1'b1, 31, 1, 1, 8'h7F)); // 7 ones left
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h1234_5678, 1'b0, 0,  1, 0, 8'h00)); // zero width
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'h0000_0000, 1'b0, 0,  1, 0, 8'h00)); // still empty
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h8000_0000, 1'b0, 31, 0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h0000_0000, 1'b0, 1,  0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h2000_0000, 1'b1, 5,  0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, -32'sd341782638, 1'b0, 13, 0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'sd341782637,  1'b0, 7,  0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'h0000_0000, 1'b0, 0,  0, 0, 8'h00));
    add_row(mk(ROW_MIN,  ACT_QUANT, 32'h8000_0000, 1'b0, 0,  0, 0, 8'h00)); // full range
    add_row(mk(ROW_MAX,  ACT_QUANT, 32'h7FFF_FFFF, 1'b0, 0,  0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h7FFF_FFFF, 1'b0, 31, 0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h8000_0000, 1'b0, 17, 0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h0000_0000, 1'b0, 24, 0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'h0000_0000, 1'b0, 0,  0, 0, 8'h00));
    add_row(mk(ROW_MIN,  ACT_QUANT, 32'h0010_0000, 1'b0, 0,  0, 0, 8'h00)); // empty range
    add_row(mk(ROW_MAX,  ACT_QUANT, 32'h0010_0000, 1'b0, 0,  0, 0, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h0010_0000, 1'b0, 8,  1, 1, 8'h00));
    add_row(mk(ROW_MAX,  ACT_QUANT, 32'hFFF0_0000, 1'b0, 0,  0, 0, 8'h00)); // inverted
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h7FFF_FFFF, 1'b0, 8,  1, 1, 8'h00));
    add_row(mk(ROW_ITEM, ACT_QUANT, 32'h2000_0000, 1'b1, 8,  0, 0, 8'h00)); // zeroth ok
    add_row(mk(ROW_ITEM, ACT_FLUSH, 32'h0000_0000, 1'b0, 0,  0, 0, 8'h00));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_MIN: write_reg(REG_RANGE_MIN, plan[i].item.sample);
        ROW_MAX: write_reg(REG_RANGE_MAX, plan[i].item.sample);
        default: send_and_book(plan[i].item, plan[i].typed, plan[i].typed_n,
                               plan[i].typed_byte);
      endcase
    end

    // Random phases: each picks a range setting; odd phases run with no idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo_val = RANGE_MIN_RESET; hi_val = RANGE_MAX_RESET; end
        1: begin lo_val = 32'h8000_0000;   hi_val = 32'h7FFF_FFFF;   end
        3: begin lo_val = $urandom;        hi_val = lo_val;          end
        4: begin lo_val = $urandom_range(1, 32'h7FFF_FFFF);
                 hi_val = lo_val - $urandom_range(1, 32'h0FFF_FFFF); end
        5: begin lo_val = $urandom;        hi_val = lo_val + $urandom_range(1, 4096); end
        6: begin lo_val = 32'h0000_0000;   hi_val = 32'h4000_0000;   end
        default: begin
          lo_val = $urandom;
          hi_val = $urandom;
          if ($signed(hi_val) < $signed(lo_val)) {lo_val, hi_val} = {hi_val, lo_val};
        end
      endcase
      calm = 1'b0;
      write_reg(REG_RANGE_MIN, lo_val);
      write_reg(REG_RANGE_MAX, hi_val);
      calm = p[0];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Mid-phase, let the block run dry once before carrying on.
        if (p == 2 && k == PHASE_ITEMS / 2) wait_drained();
        send_and_book(draw_item(), 1'b0, 0, 8'h00);
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d items (%0d flushes) and %0d register writes over %0d range phases",
             items_sent, flush_sent, reg_writes, PHASES);
    $display("%0d output bytes compared, %0d mismatches", checked, errors);
    if (errors == 0 && bytes_due.size() == 0) begin
      $display("moment_quantize_bit_packer_tb: clean");
    end else begin
      $display("moment_quantize_bit_packer_tb: errors");
    end
    $finish;
  end

endmodule
